// ----- sv/sida_pkg.sv -----
// shared types and constants for the signed integer to decimal ascii converter
package sida_pkg;

    localparam int BIN_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int PTR_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(BIN_W);
    localparam int CHAR_W     = 6;

    localparam logic [CNT_W-1:0]  SHIFT_LAST = CNT_W'(BIN_W - 1);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic find;
        logic emit_sign;
        logic emit_digit;
    } sida_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic neg;
        logic last_digit;
        logic out_free;
    } sida_sts_t;

endpackage

// ----- sv/sida_dp.sv -----
// datapath: magnitude, shift-add-3 binary to bcd conversion and output register
module sida_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sida_pkg::sida_cmd_t           cmd,
    output sida_pkg::sida_sts_t           sts,
    input  logic [sida_pkg::BIN_W-1:0]    s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sida_pkg::CHAR_W-1:0]   m_text_char,
    output logic                          m_last_char
);
    import sida_pkg::*;

    logic [BIN_W-1:0]  bin_reg;
    logic [BCD_W-1:0]  bcd_reg;
    logic [BCD_W-1:0]  bcd_adj;
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic              neg_reg;
    logic [DIGIT_W-1:0] cur_digit;
    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_text_char_reg;
    logic              m_last_char_reg;
    logic              out_free;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // index of the most significant nonzero digit, zero when all are zero
    always_comb begin
        ptr_next = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] != '0) begin
                ptr_next = PTR_W'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[ptr_reg*DIGIT_W +: DIGIT_W];
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg <= s_value[BIN_W-1];
            bin_reg <= s_value[BIN_W-1] ? (~s_value + BIN_W'(1)) : s_value;
            bcd_reg <= '0;
        end else if (cmd.shift) begin
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_reg <= {bin_reg[BIN_W-2:0], 1'b0};
        end
        if (cmd.find) begin
            ptr_reg <= ptr_next;
        end else if (cmd.emit_digit && ptr_reg != '0) begin
            ptr_reg <= ptr_reg - PTR_W'(1);
        end
        if (cmd.emit_sign) begin
            m_text_char_reg <= CHAR_MINUS;
            m_last_char_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            m_text_char_reg <= CHAR_ZERO | CHAR_W'(cur_digit);
            m_last_char_reg <= (ptr_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.neg        = neg_reg;
    assign sts.last_digit = (ptr_reg == '0);
    assign sts.out_free   = out_free;

    assign m_valid     = m_valid_reg;
    assign m_text_char = m_text_char_reg;
    assign m_last_char = m_last_char_reg;

endmodule

// ----- sv/sida_ctrl.sv -----
// controller: sequences load, conversion shifts, digit search and character emission
module sida_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output sida_pkg::sida_cmd_t   cmd,
    input  sida_pkg::sida_sts_t   sts
);
    import sida_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                    if (s_valid) begin
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == SHIFT_LAST) begin
                        state_reg <= ST_FIND;
                    end
                end
                ST_FIND: begin
                    state_reg <= sts.neg ? ST_SIGN : ST_DIGIT;
                end
                ST_SIGN: begin
                    if (sts.out_free) begin
                        state_reg <= ST_DIGIT;
                    end
                end
                ST_DIGIT: begin
                    if (sts.out_free && sts.last_digit) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign cmd.load       = (state_reg == ST_IDLE) && s_valid;
    assign cmd.shift      = (state_reg == ST_CONV);
    assign cmd.find       = (state_reg == ST_FIND);
    assign cmd.emit_sign  = (state_reg == ST_SIGN) && sts.out_free;
    assign cmd.emit_digit = (state_reg == ST_DIGIT) && sts.out_free;

endmodule

// ----- sv/signed_int_to_decimal_ascii.sv -----
// top level: signed 32-bit integer to decimal ascii character stream
//
// channel  dir  ports                                   transaction
// s_       in   s_valid s_ready s_value[31:0]           one signed integer
// m_       out  m_valid m_ready m_text_char[5:0]        one character, m_last_char on the final one
//
// an accept, the shift-add-3 steps of the bcd converter (one per input bit), a search
// for the leading digit, then one character per cycle (1 to 11 characters) while the
// output is not stalled. a stall on m_ready holds the controller in its emit state.
// synchronous active-low reset clears the controller and the output valid; the
// converter holds no state between transactions.
module signed_int_to_decimal_ascii (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sida_pkg::BIN_W-1:0]    s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sida_pkg::CHAR_W-1:0]   m_text_char,
    output logic                          m_last_char
);
    import sida_pkg::*;

    sida_cmd_t cmd;
    sida_sts_t sts;

    sida_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    sida_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last_char (m_last_char)
    );

endmodule

// ----- dv/tb_signed_int_to_decimal_ascii.sv -----
// testbench for the signed integer to decimal ascii converter
module tb_signed_int_to_decimal_ascii;
    timeunit 1ns;
    timeprecision 1ps;

    import sida_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
    } ascii_char_t;

    typedef struct {
        logic [BIN_W-1:0] value;
        int unsigned      gap_after;
        bit               drain;
    } number_item_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [BIN_W-1:0]  s_value;
    logic              m_valid;
    logic              m_ready;
    logic [CHAR_W-1:0] m_text_char;
    logic              m_last_char;

    number_item_t number_q[$];
    ascii_char_t  char_q[$];

    logic        in_accepted;
    logic        out_accepted;
    int unsigned in_wait;
    int unsigned out_stall;
    int unsigned stall_draw;
    int unsigned char_count;
    int unsigned cycle_count;
    int unsigned error_count;
    number_item_t cur_item;

    signed_int_to_decimal_ascii i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last_char (m_last_char)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // appends the decimal text of one number to the expected characters
    function automatic void push_decimal_text(logic [BIN_W-1:0] number);
        logic [BIN_W-1:0] mag;
        logic [3:0]       digit_buf[10];
        int               nd;
        ascii_char_t      ch;
        nd = 0;
        mag = number[BIN_W-1] ? (32'd0 - number) : number;
        do begin
            digit_buf[nd] = 4'(mag % 10);
            mag = mag / 10;
            nd++;
        end while (mag != 0 && nd < 10);
        if (number[BIN_W-1]) begin
            ch.text_char = CHAR_MINUS;
            ch.last_char = 1'b0;
            char_q.push_back(ch);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            ch.text_char = CHAR_ZERO + CHAR_W'(digit_buf[i]);
            ch.last_char = (i == 0);
            char_q.push_back(ch);
        end
    endfunction

    function automatic void add_number(logic [BIN_W-1:0] number, int unsigned gap, bit drain);
        number_item_t it;
        it.value = number;
        it.gap_after = gap;
        it.drain = drain;
        number_q.push_back(it);
    endfunction

    // random value with a chosen digit count and sign, or in one draw of six a fully random word
    function automatic logic [BIN_W-1:0] random_number();
        longint lo;
        longint hi;
        longint mag;
        int     nd;
        nd = $urandom_range(1, 10);
        lo = (nd == 1) ? 0 : 10 ** (nd - 1);
        hi = longint'(10) ** nd - 1;
        if (hi > 64'd2147483647) begin
            hi = 64'd2147483647;
        end
        case ($urandom_range(0, 5))
            0: begin
                return $urandom();
            end
            1: begin
                // power of ten or its neighbors
                mag = lo + $urandom_range(0, 2) - 1;
                if (mag < 0) begin
                    mag = 0;
                end
            end
            default: begin
                mag = lo + $urandom_range(0, 32'(hi - lo));
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            return 32'd0 - 32'(mag);
        end
        return 32'(mag);
    endfunction

    // prediction on accepted inputs, comparison on accepted characters
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        in_accepted <= aresetn && s_valid && s_ready;
        out_accepted <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            push_decimal_text(s_value);
        end
        if (aresetn && m_valid && m_ready) begin
            char_count <= char_count + 1;
            if (char_q.size() == 0) begin
                $error("unexpected transaction: text_char %0d last_char %0d",
                       m_text_char, m_last_char);
                error_count++;
            end else begin
                if (m_text_char !== char_q[0].text_char) begin
                    $error("text_char mismatch: expected %0d actual %0d",
                           char_q[0].text_char, m_text_char);
                    error_count++;
                end
                if (m_last_char !== char_q[0].last_char) begin
                    $error("last_char mismatch: expected %0d actual %0d",
                           char_q[0].last_char, m_last_char);
                    error_count++;
                end
                void'(char_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_signed_int_to_decimal_ascii failed");
            $finish;
        end
    end

    // driver: hold each transaction until accepted, then idle for its gap
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && !in_accepted)) begin
            if (in_wait != 0) begin
                in_wait <= in_wait - 1;
                s_valid <= 1'b0;
            end else if (number_q.size() != 0 && !(number_q[0].drain && char_q.size() != 0)) begin
                cur_item = number_q.pop_front();
                s_value <= cur_item.value;
                s_valid <= 1'b1;
                in_wait <= cur_item.gap_after;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: stall a random number of cycles before each character
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_accepted) begin
                // no stalls in one stretch out of four
                stall_draw = (char_count[7:6] == 2'b11) ? 0 : $urandom_range(0, 9);
                out_stall <= stall_draw;
                m_ready <= (stall_draw == 0);
            end else if (out_stall != 0) begin
                out_stall <= out_stall - 1;
                m_ready <= (out_stall == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_value = '0;
        m_ready = 1'b0;
        in_accepted = 1'b0;
        out_accepted = 1'b0;
        in_wait = 0;
        out_stall = 0;
        stall_draw = 0;
        char_count = 0;
        cycle_count = 0;
        error_count = 0;

        // directed: zero, single digits, width boundaries, most negative value
        add_number(32'd0, $urandom_range(0, 9), 1'b0);
        add_number(32'd1, $urandom_range(0, 9), 1'b0);
        add_number(32'hFFFF_FFFF, $urandom_range(0, 9), 1'b0);
        add_number(32'd9, 0, 1'b0);
        add_number(32'd10, 0, 1'b0);
        add_number(-32'sd10, 0, 1'b0);
        add_number(32'd99, $urandom_range(0, 9), 1'b0);
        add_number(32'd100, $urandom_range(0, 9), 1'b0);
        add_number(32'h7FFF_FFFF, $urandom_range(0, 9), 1'b0);
        add_number(32'h8000_0000, $urandom_range(0, 9), 1'b1);
        add_number(32'h8000_0001, 0, 1'b0);
        add_number(32'd999999999, 0, 1'b0);
        add_number(32'd1000000000, 0, 1'b0);
        add_number(-32'sd999999999, $urandom_range(0, 9), 1'b0);
        add_number(-32'sd1000000000, $urandom_range(0, 9), 1'b0);
        add_number(32'h5555_5555, 0, 1'b0);
        add_number(32'hAAAA_AAAA, 0, 1'b0);
        add_number(32'd1234567890, $urandom_range(0, 9), 1'b0);
        add_number(-32'sd1234567890, $urandom_range(0, 9), 1'b1);
        add_number(32'd0, 0, 1'b0);
        add_number(-32'sd1, 0, 1'b0);
        add_number(32'd7, 0, 1'b0);

        for (int k = 0; k < 330; k++) begin
            add_number(random_number(),
                       ((k / 40) % 4 == 2) ? 0 : $urandom_range(0, 9),
                       (k % 97) == 50);
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (number_q.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (char_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("tb_signed_int_to_decimal_ascii passed");
        end else begin
            $display("tb_signed_int_to_decimal_ascii failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/sida_pkg.sv
sv/sida_dp.sv
sv/sida_ctrl.sv
sv/signed_int_to_decimal_ascii.sv
dv/tb_signed_int_to_decimal_ascii.sv
